### src/ptt_pkg.sv
// ptt_pkg: item types, table entry type, operation and status codes for the
// periodic timer table; no dependencies
`default_nettype none

package ptt_pkg;

  localparam logic [9:0] INTERVAL_LIMIT = 10'd1000;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_TICK       = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ID_ZERO      = 3'd1,
    ST_HANDLER_ZERO = 3'd2,
    ST_INTERVAL     = 3'd3,
    ST_DUPLICATE    = 3'd4,
    ST_FULL         = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] message_id;
    logic [15:0] handler_id;
    logic [9:0]  interval_ms;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        fired;
    logic [31:0] fire_message_id;
    logic [15:0] fire_handler_id;
    logic [31:0] fire_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] msg;
    logic [15:0] hnd;
    logic [9:0]  ivl;
    logic [31:0] last_fire;
    logic [31:0] count;
  } entry_t;

  // what the head of the chain reports about the entry it holds
  typedef struct packed {
    logic   match;
    logic   fire;
    entry_t upd;
  } head_res_t;

endpackage

`default_nettype wire

### src/ptt_cell.sv
// ptt_cell: one storage cell of the timer chain, takes its neighbour's entry
// on every shift; depends on ptt_pkg
`default_nettype none

module ptt_cell
  import ptt_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    en_i,
  input  entry_t d_i,
  output entry_t q_o
);

  entry_t q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (en_i) begin
      q_q <= d_i;
    end
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

### src/ptt_head.sv
// ptt_head: compare and fire check on the entry at the head of the chain
// depends on ptt_pkg
`default_nettype none

module ptt_head
  import ptt_pkg::*;
(
  input  entry_t      head_i,
  input  wire [31:0]  msg_i,
  input  wire [15:0]  hnd_i,
  input  wire [31:0]  now_i,
  output head_res_t   res_o
);

  logic [31:0] elapsed;

  always_comb begin
    elapsed           = now_i - head_i.last_fire;
    res_o.match       = head_i.valid && (head_i.msg == msg_i) && (head_i.hnd == hnd_i);
    res_o.fire        = head_i.valid && (elapsed >= {22'd0, head_i.ivl});
    res_o.upd         = head_i;
    res_o.upd.last_fire = now_i;
    res_o.upd.count   = head_i.count + 32'd1;
  end

endmodule

`default_nettype wire

### src/periodic_timer_table.sv
// periodic_timer_table: an item is taken only while idle, then the whole chain
// rotates once through the head and one finishing step follows; both the
// rotation and the finishing step wait while the output register is full.
// the final result is registered in the finishing step.
// reset (async, active low) empties the table and clears all valid bits.
// depends on ptt_pkg, ptt_cell, ptt_head
`default_nettype none

module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  output out_item_t out_item_o
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_STEP = IW'(MAX_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e    state_q, state_d;
  logic [IW-1:0] step_q, step_d;
  logic [CW-1:0] total_q, total_d;
  in_item_t  item_q, item_d;
  status_e   st_q, st_d;
  logic      act_q, act_d;     // register item passed its field checks
  logic      dup_q, dup_d;     // duplicate pair seen during the scan
  logic      ins_q, ins_d;     // new entry went into the chain
  logic      rem_q, rem_d;     // entry taken out, chain now wraps one short
  out_item_t pend_q, pend_d;   // newest fire, held back until the next one
  logic      pend_vq, pend_vd;
  out_item_t out_q, out_d;
  logic      out_vq, out_vd;

  entry_t    cell_q [MAX_ENTRIES];
  entry_t    cell_d [MAX_ENTRIES];
  entry_t    head, feed, new_e, blank;
  head_res_t hres;
  logic      slot_free, scan_adv, is_reg, is_unreg, is_tick;
  logic      drop, ins, fire;
  status_e   chk;
  logic [MAX_ENTRIES-1:0] vld_vec, therm;

  assign head = cell_q[0];

  ptt_head u_head (
    .head_i (head),
    .msg_i  (item_q.message_id),
    .hnd_i  (item_q.handler_id),
    .now_i  (item_q.now_ms),
    .res_o  (hres)
  );

  // new entry and empty slot
  always_comb begin
    new_e           = '0;
    new_e.valid     = 1'b1;
    new_e.msg       = item_q.message_id;
    new_e.hnd       = item_q.handler_id;
    new_e.ivl       = item_q.interval_ms;
    blank           = '0;
  end

  assign is_reg   = (item_q.opcode == OP_REGISTER);
  assign is_unreg = (item_q.opcode == OP_UNREGISTER);
  assign is_tick  = (item_q.opcode == OP_TICK);
  assign slot_free = !out_vq || out_ready_i;
  assign scan_adv  = (state_q == S_SCAN) && slot_free;

  // head decisions for this step
  assign drop = is_unreg && hres.match && !rem_q;
  // every valid entry has already been checked by the time the step reaches the fill level
  assign ins  = is_reg && act_q && !dup_q && !ins_q && (CW'(step_q) == total_q);
  assign fire = is_tick && hres.fire;

  // what the head hands back to the tail
  always_comb begin
    if (fire) begin
      feed = hres.upd;
    end else if (ins) begin
      feed = new_e;
    end else begin
      feed = head;
    end
  end

  // chain wiring: each cell takes its upper neighbour; after a removal the
  // ring closes one cell early and the top cell holds an empty slot
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_chain
    if (i == MAX_ENTRIES - 1) begin : g_top
      assign cell_d[i] = (drop || rem_q) ? blank : feed;
    end else if (i == MAX_ENTRIES - 2) begin : g_wrap
      assign cell_d[i] = rem_q ? feed : cell_q[i+1];
    end else begin : g_mid
      assign cell_d[i] = cell_q[i+1];
    end

    ptt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (scan_adv),
      .d_i    (cell_d[i]),
      .q_o    (cell_q[i])
    );

    assign vld_vec[i] = cell_q[i].valid;
  end

  // field checks in priority order
  always_comb begin
    if (in_item_i.message_id == 32'd0) begin
      chk = ST_ID_ZERO;
    end else if (in_item_i.handler_id == 16'd0) begin
      chk = ST_HANDLER_ZERO;
    end else if (in_item_i.interval_ms > INTERVAL_LIMIT) begin
      chk = ST_INTERVAL;
    end else begin
      chk = ST_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    total_d = total_q;
    item_d  = item_q;
    st_d    = st_q;
    act_d   = act_q;
    dup_d   = dup_q;
    ins_d   = ins_q;
    rem_d   = rem_q;
    pend_d  = pend_q;
    pend_vd = pend_vq;
    out_d   = out_q;
    out_vd  = out_vq && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          st_d    = (in_item_i.opcode == OP_REGISTER) ? chk : ST_OK;
          act_d   = (in_item_i.opcode == OP_REGISTER) && (chk == ST_OK);
          dup_d   = 1'b0;
          ins_d   = 1'b0;
          rem_d   = 1'b0;
          pend_vd = 1'b0;
          step_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (slot_free) begin
          step_d = step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            state_d = S_FINISH;
          end
          if (is_reg && hres.match) begin
            dup_d = 1'b1;
          end
          if (ins) begin
            ins_d   = 1'b1;
            total_d = total_q + 1'b1;
          end
          if (drop) begin
            rem_d   = 1'b1;
            total_d = total_q - 1'b1;
          end
          if (fire) begin
            // earlier fire is now known not to be the final one
            if (pend_vq) begin
              out_d  = pend_q;
              out_vd = 1'b1;
            end
            pend_d                 = '0;
            pend_d.status          = ST_OK;
            pend_d.fired           = 1'b1;
            pend_d.fire_message_id = hres.upd.msg;
            pend_d.fire_handler_id = hres.upd.hnd;
            pend_d.fire_count      = hres.upd.count;
            pend_vd                = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_vd = 1'b1;
          out_d  = '0;
          out_d.status = st_q;
          out_d.last   = 1'b1;
          if (is_reg && (st_q == ST_OK)) begin
            if (dup_q) begin
              out_d.status = ST_DUPLICATE;
            end else if (!ins_q) begin
              out_d.status = ST_FULL;
            end
          end
          if (is_tick && pend_vq) begin
            out_d      = pend_q;
            out_d.last = 1'b1;
          end
          pend_vd = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      total_q <= '0;
      act_q   <= 1'b0;
      dup_q   <= 1'b0;
      ins_q   <= 1'b0;
      rem_q   <= 1'b0;
      pend_vq <= 1'b0;
      out_vq  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      total_q <= total_d;
      act_q   <= act_d;
      dup_q   <= dup_d;
      ins_q   <= ins_d;
      rem_q   <= rem_d;
      pend_vq <= pend_vd;
      out_vq  <= out_vd;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    st_q   <= st_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vq;
  assign out_item_o  = out_q;

  // expected valid pattern: entries packed at the front up to the fill level
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      therm[i] = (CW'(i) < total_q);
    end
  end

  // fill level never passes the table depth
  a_total_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MAX_ENTRIES))
    else $error("fill level above table depth");

  // between items the valid entries form one block at the head of the chain
  a_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (vld_vec == therm))
    else $error("table entries not packed");

  // the finishing cycle always delivers the item's final result
  a_finish_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FINISH) && slot_free) |=> (out_valid_o && out_item_o.last))
    else $error("finishing result not flagged last");

endmodule

`default_nettype wire

### tb/ptt_timer_check.sv
// ptt_timer_check: watches both item channels of periodic_timer_table, keeps
// its own copy of the timer table and compares every result item in order
// depends on ptt_pkg
module ptt_timer_check
  import ptt_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  in_item_t   in_item_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  out_item_t  out_item_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         fires_o,
  output logic [5:0] status_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // timer table, always packed from index 0 in registration order
  logic [31:0] tmr_msg   [DEPTH];
  logic [15:0] tmr_hnd   [DEPTH];
  logic [9:0]  tmr_ivl   [DEPTH];
  logic [31:0] tmr_fired [DEPTH];
  logic [31:0] tmr_count [DEPTH];
  int          tmr_live = 0;

  out_item_t   awaited_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          fires_seen = 0;
  logic [5:0]  codes_seen = '0;

  assign fail_count_o  = mismatches;
  assign checked_o     = results_seen;
  assign fires_o       = fires_seen;
  assign status_seen_o = codes_seen;

  initial pending_o = 0;

  function automatic status_e add_timer(input logic [31:0] msg, input logic [15:0] hnd,
                                        input logic [9:0] ivl);
    if (msg == '0) return ST_ID_ZERO;
    if (hnd == '0) return ST_HANDLER_ZERO;
    if (ivl > INTERVAL_LIMIT) return ST_INTERVAL;
    for (int i = 0; i < tmr_live; i++)
      if (tmr_msg[i] == msg && tmr_hnd[i] == hnd) return ST_DUPLICATE;
    if (tmr_live >= DEPTH) return ST_FULL;
    tmr_msg[tmr_live]   = msg;
    tmr_hnd[tmr_live]   = hnd;
    tmr_ivl[tmr_live]   = ivl;
    tmr_fired[tmr_live] = '0;
    tmr_count[tmr_live] = '0;
    tmr_live++;
    return ST_OK;
  endfunction

  // first matching pair goes, later entries move down one place
  task automatic drop_timer(input logic [31:0] msg, input logic [15:0] hnd);
    int hit;
    hit = -1;
    for (int i = 0; i < tmr_live; i++)
      if (hit < 0 && tmr_msg[i] == msg && tmr_hnd[i] == hnd) hit = i;
    if (hit >= 0) begin
      for (int j = hit; j + 1 < tmr_live; j++) begin
        tmr_msg[j]   = tmr_msg[j + 1];
        tmr_hnd[j]   = tmr_hnd[j + 1];
        tmr_ivl[j]   = tmr_ivl[j + 1];
        tmr_fired[j] = tmr_fired[j + 1];
        tmr_count[j] = tmr_count[j + 1];
      end
      tmr_live--;
    end
  endtask

  task automatic predict(input in_item_t it);
    out_item_t        plain;
    out_item_t        fire;
    logic [DEPTH-1:0] due;
    logic [31:0]      elapsed;
    int               last_idx;
    plain        = '0;
    plain.status = ST_OK;
    plain.last   = 1'b1;
    case (it.opcode)
      OP_REGISTER: begin
        plain.status = add_timer(it.message_id, it.handler_id, it.interval_ms);
        awaited_q.push_back(plain);
      end
      OP_UNREGISTER: begin
        drop_timer(it.message_id, it.handler_id);
        awaited_q.push_back(plain);
      end
      OP_TICK: begin
        due      = '0;
        last_idx = -1;
        for (int i = 0; i < tmr_live; i++) begin
          elapsed = it.now_ms - tmr_fired[i];
          due[i]  = (elapsed >= {22'd0, tmr_ivl[i]});
          if (due[i]) last_idx = i;
        end
        if (last_idx < 0) awaited_q.push_back(plain);
        for (int i = 0; i < tmr_live; i++) begin
          if (due[i]) begin
            tmr_fired[i]         = it.now_ms;
            tmr_count[i]         = tmr_count[i] + 32'd1;
            fire                 = '0;
            fire.status          = ST_OK;
            fire.fired           = 1'b1;
            fire.fire_message_id = tmr_msg[i];
            fire.fire_handler_id = tmr_hnd[i];
            fire.fire_count      = tmr_count[i];
            fire.last            = (i == last_idx);
            awaited_q.push_back(fire);
          end
        end
      end
      default: begin
        awaited_q.push_back(plain);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v, inout bit ok);
    if (got_v !== want_v) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want_v, got_v);
      ok = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    bit        ok;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t ns: unexpected result item %h", $time, out_item_i);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          ok   = 1'b1;
          check_field("status", 32'(want.status), 32'(out_item_i.status), ok);
          check_field("fired", 32'(want.fired), 32'(out_item_i.fired), ok);
          check_field("fire_message_id", want.fire_message_id,
                      out_item_i.fire_message_id, ok);
          check_field("fire_handler_id", 32'(want.fire_handler_id),
                      32'(out_item_i.fire_handler_id), ok);
          check_field("fire_count", want.fire_count, out_item_i.fire_count, ok);
          check_field("last", 32'(want.last), 32'(out_item_i.last), ok);
          if (!ok) mismatches++;
          results_seen++;
          if (want.fired) fires_seen++;
          codes_seen[want.status] = 1'b1;
        end
      end
      if (in_valid_i && in_ready_i) predict(in_item_i);
      pending_o <= awaited_q.size();
    end
  end

endmodule

### tb/tb_periodic_timer_table.sv
// tb_periodic_timer_table: drives register, unregister, tick and unused-code items into the
// periodic timer table with random gaps and stalls, then gives the verdict
// depends on ptt_pkg, ptt_timer_check and the periodic_timer_table rtl
module tb_periodic_timer_table
  import ptt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  // the code that the block ignores, it still answers with one plain item
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM    = 190;
  // ample settle time after the last result
  localparam int SETTLE      = 40;
  // longest honest quiet stretch is the long receiver hold plus one pass
  localparam int HOLD_CYCLES = 250;
  localparam int QUIET_LIMIT = 2000;
  localparam int LOG_SIZE    = 32;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int         fail_count;
  int         pending;
  int         checked;
  int         fires;
  logic [5:0] status_seen;

  // stimulus bookkeeping, written only by the stimulus process
  int          items_sent = 0;
  int          ticks_sent = 0;
  bit          calm       = 1'b0;
  logic [31:0] clock_ms   = 32'd2000;
  // recently offered pairs, so that duplicates and removals actually hit
  logic [31:0] log_msg [LOG_SIZE];
  logic [15:0] log_hnd [LOG_SIZE];
  int          log_n  = 0;
  int          log_wr = 0;

  always #1 clk_i = ~clk_i;

  periodic_timer_table #(
    .MAX_ENTRIES(DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  ptt_timer_check #(
    .DEPTH(DEPTH)
  ) timer_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .fires_o      (fires),
    .status_seen_o(status_seen)
  );

  // every field random, so that ignored fields toggle as well
  function automatic in_item_t noise_item(input logic [1:0] op);
    in_item_t it;
    it.opcode      = op;
    it.message_id  = $urandom();
    it.handler_id  = 16'($urandom());
    it.interval_ms = 10'($urandom());
    it.now_ms      = $urandom();
    return it;
  endfunction

  // clean: always a fresh, well-formed pair (used to fill the table)
  function automatic in_item_t make_register(input bit clean);
    in_item_t it;
    int       pick;
    int       idx;
    it   = noise_item(OP_REGISTER);
    pick = clean ? 99 : $urandom_range(0, 99);
    if (it.message_id == '0) it.message_id = 32'd1;
    if (it.handler_id == '0) it.handler_id = 16'd1;
    if ($urandom_range(0, 2) == 0) it.interval_ms = 10'($urandom_range(0, 40));
    else it.interval_ms = 10'($urandom_range(0, 1000));
    if (pick < 5) begin
      it.message_id = '0;
    end else if (pick < 10) begin
      it.handler_id = '0;
    end else if (pick < 17) begin
      it.interval_ms = 10'($urandom_range(1001, 1023));
    end else if (pick < 32 && log_n > 0) begin
      // same pair again, the interval does not matter for the duplicate check
      idx           = $urandom_range(0, log_n - 1);
      it.message_id = log_msg[idx];
      it.handler_id = log_hnd[idx];
    end else begin
      log_msg[log_wr] = it.message_id;
      log_hnd[log_wr] = it.handler_id;
      log_wr          = (log_wr + 1) % LOG_SIZE;
      if (log_n < LOG_SIZE) log_n++;
    end
    return it;
  endfunction

  function automatic in_item_t make_unregister();
    in_item_t it;
    int       pick;
    int       idx;
    it   = noise_item(OP_UNREGISTER);
    pick = $urandom_range(0, 99);
    if (pick < 70 && log_n > 0) begin
      idx           = $urandom_range(0, log_n - 1);
      it.message_id = log_msg[idx];
      it.handler_id = log_hnd[idx];
    end else if (pick < 80) begin
      it.message_id = '0;
    end else if (pick < 90) begin
      it.handler_id = '0;
    end
    return it;
  endfunction

  // time mostly creeps forward, now and then it jumps anywhere (wrap)
  function automatic in_item_t make_tick();
    in_item_t it;
    it = noise_item(OP_TICK);
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom();
    else clock_ms = clock_ms + 32'($urandom_range(0, 300));
    it.now_ms = clock_ms;
    return it;
  endfunction

  // offer one item and hold it until the block takes it; valid is only
  // lowered when a gap is actually inserted
  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (it.opcode == OP_TICK) ticks_sent++;
  endtask

  task automatic offer(input logic [1:0] op, input logic [31:0] msg,
                       input logic [15:0] hnd, input logic [9:0] ivl,
                       input logic [31:0] now);
    in_item_t it;
    it.opcode      = op;
    it.message_id  = msg;
    it.handler_id  = hnd;
    it.interval_ms = ivl;
    it.now_ms      = now;
    send_item(it);
  endtask

  // stop offering until every predicted result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // receiver: random stalls, a calm window, and one long hold-off while the
  // sender keeps offering, so the block backs up and refuses input
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && items_sent >= 70) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // watchdog: ends the run if no item moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no item moved for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    in_item_t it;
    int       pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on an empty table: nothing fires
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'd0);
    // each rejection reason in priority order
    offer(OP_REGISTER, 32'd0, 16'd5, 10'd10, 32'd0);
    offer(OP_REGISTER, 32'd7, 16'd0, 10'd10, 32'd0);
    offer(OP_REGISTER, 32'd7, 16'd5, 10'd1001, 32'd0);
    offer(OP_REGISTER, 32'd7, 16'd5, 10'd1023, 32'd0);
    // all-ones ids with the largest legal interval, then a zero interval
    offer(OP_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 10'd1000, 32'hFFFF_FFFF);
    offer(OP_REGISTER, 32'd7, 16'd5, 10'd0, 32'd0);
    offer(OP_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 10'd3, 32'd0);
    // same id, other handler: a distinct entry
    offer(OP_REGISTER, 32'd7, 16'd6, 10'd500, 32'd0);
    // elapsed exactly at the interval, one short of it, and across the wrap
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'd0);
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'd999);
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'd1000);
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'hFFFF_FFFF);
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'd3);
    // removal of the head entry, a missing pair and pairs with zero fields
    offer(OP_UNREGISTER, 32'hFFFF_FFFF, 16'hFFFF, 10'd0, 32'd0);
    offer(OP_UNREGISTER, 32'd7, 16'd7, 10'd0, 32'd0);
    offer(OP_UNREGISTER, 32'd0, 16'd0, 10'd0, 32'd0);
    offer(OP_UNREGISTER, 32'd0, 16'd5, 10'd0, 32'd0);
    offer(OP_UNREGISTER, 32'd7, 16'd0, 10'd0, 32'd0);
    // unused code with every payload bit set
    offer(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 32'hFFFF_FFFF);
    // counts carried on after the gap was closed, then a tick where none is due
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'd1503);
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'd1503);
    offer(OP_UNREGISTER, 32'd7, 16'd5, 10'd0, 32'd0);
    offer(OP_TICK, 32'd0, 16'd0, 10'd0, 32'd1504);
    drain();

    // random part: fill the table with clean registrations first (so the
    // full case is reached), then a mix that keeps it busy and churning
    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 100 && i < 140);
      if (i == 60 || i == 150) drain();
      if (i < 24) begin
        it = make_register(1'b1);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) it = make_register(1'b0);
        else if (pick < 50) it = make_unregister();
        else if (pick < 95) it = make_tick();
        else it = noise_item(OP_UNUSED);
      end
      send_item(it);
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d items (%0d ticks), %0d results compared, %0d of them fires",
             items_sent, ticks_sent, checked, fires);
    $display("status codes returned (bit per code, ok in bit 0): %b, mismatches %0d",
             status_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
